### rtl/core/rrwl_pkg.sv
// ----------------------------------------------------------------------------
// Reader-writer lock package
// Shared beat types, operation and status codes, and the control groups that
// pass between the slot table, the decision logic and the top level.
// ----------------------------------------------------------------------------
package rrwl_pkg;

   typedef enum logic [1:0] {
      OP_READ_ACQUIRE  = 2'd0,
      OP_READ_RELEASE  = 2'd1,
      OP_WRITE_ACQUIRE = 2'd2,
      OP_WRITE_RELEASE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_WAIT     = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOT_HELD = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      op_type     req_type;
      logic [7:0] thread_id;
   } req_beat_type;

   typedef struct packed {
      status_type status;
      logic [3:0] reader_threads;
      logic [7:0] own_read_depth;
      logic [7:0] write_nesting;
   } rsp_beat_type;

   // Lookup results of the reader slot table for the requesting thread.
   typedef struct packed {
      logic hit;
      logic has_free;
      logic other_reader;
      logic count_max;
      logic count_one;
   } slot_flags_type;

   typedef struct packed {
      logic busy;
      logic owner_match;
      logic depth_max;
   } writer_flags_type;

   typedef struct packed {
      logic inc;
      logic dec;
      logic alloc;
   } slot_cmd_type;

   typedef struct packed {
      status_type   status;
      slot_cmd_type slot_cmd;
      logic         wr_inc;
      logic         wr_dec;
   } decision_type;

endpackage

### rtl/core/rrwl_slot_table.sv
// ----------------------------------------------------------------------------
// Reader slot table
// Holds one thread and nesting count per slot, matches the requesting thread
// against all slots in parallel and applies the granted update.
// ----------------------------------------------------------------------------
module rrwl_slot_table #(
   parameter int SLOTS    = 8,
   parameter int TID_BITS = 8,
   parameter int CNT_BITS = 8,
   localparam int RW      = $clog2(SLOTS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  rrwl_pkg::slot_cmd_type cmd,
   input  logic [TID_BITS-1:0]    tid,
   output rrwl_pkg::slot_flags_type flags,
   output logic [CNT_BITS-1:0]    own_count,
   output logic [RW-1:0]          readers
);

   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic [TID_BITS-1:0] thread_ff [SLOTS];
   logic [CNT_BITS-1:0] count_ff  [SLOTS];
   logic [RW-1:0]       readers_ff, readers_in;
   logic [SLOTS-1:0]    hit_vec, other_vec, free_vec, free_pick;
   logic [CNT_BITS-1:0] new_count;

   // At most one slot matches, so the matching count is an OR over the slots.
   always_comb begin
      own_count = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit_vec[i]   = valid_ff[i] && (thread_ff[i] == tid);
         other_vec[i] = valid_ff[i] && (thread_ff[i] != tid);
         if (hit_vec[i]) begin
            own_count = own_count | count_ff[i];
         end
      end
   end

   assign free_vec  = ~valid_ff;
   assign free_pick = free_vec & (~free_vec + SLOTS'(1));

   assign flags.hit          = |hit_vec;
   assign flags.has_free     = |free_vec;
   assign flags.other_reader = |other_vec;
   assign flags.count_max    = &own_count;
   assign flags.count_one    = (own_count == CNT_BITS'(1));

   assign new_count = cmd.inc ? own_count + CNT_BITS'(1) : own_count - CNT_BITS'(1);
   assign readers   = readers_ff;

   always_comb begin
      valid_in   = valid_ff;
      readers_in = readers_ff;
      if (enable && cmd.alloc) begin
         valid_in   = valid_ff | free_pick;
         readers_in = readers_ff + RW'(1);
      end else if (enable && cmd.dec && flags.count_one) begin
         valid_in   = valid_ff & ~hit_vec;
         readers_in = readers_ff - RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         readers_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         readers_ff <= readers_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (enable && cmd.alloc && free_pick[i]) begin
            thread_ff[i] <= tid;
            count_ff[i]  <= CNT_BITS'(1);
         end else if (enable && (cmd.inc || cmd.dec) && hit_vec[i]) begin
            count_ff[i]  <= new_count;
         end
      end
   end

endmodule

### rtl/core/rrwl_decide.sv
// ----------------------------------------------------------------------------
// Request decision
// Chooses the status of one request and the state updates it grants.
// ----------------------------------------------------------------------------
module rrwl_decide (
   input  rrwl_pkg::op_type           op,
   input  rrwl_pkg::slot_flags_type   slot_flags,
   input  rrwl_pkg::writer_flags_type wr_flags,
   output rrwl_pkg::decision_type     decision
);

   always_comb begin
      decision = '{status: rrwl_pkg::ST_GRANTED, slot_cmd: '0, wr_inc: 1'b0, wr_dec: 1'b0};
      unique case (op)
         rrwl_pkg::OP_READ_ACQUIRE: begin
            if (wr_flags.busy) begin
               decision.status = rrwl_pkg::ST_WAIT;
            end else if (slot_flags.hit) begin
               if (slot_flags.count_max) begin
                  decision.status = rrwl_pkg::ST_OVERFLOW;
               end else begin
                  decision.slot_cmd.inc = 1'b1;
               end
            end else if (!slot_flags.has_free) begin
               decision.status = rrwl_pkg::ST_FULL;
            end else begin
               decision.slot_cmd.alloc = 1'b1;
            end
         end
         rrwl_pkg::OP_READ_RELEASE: begin
            if (!slot_flags.hit) begin
               decision.status = rrwl_pkg::ST_NOT_HELD;
            end else begin
               decision.slot_cmd.dec = 1'b1;
            end
         end
         rrwl_pkg::OP_WRITE_ACQUIRE: begin
            if (slot_flags.other_reader || (wr_flags.busy && !wr_flags.owner_match)) begin
               decision.status = rrwl_pkg::ST_WAIT;
            end else if (wr_flags.depth_max) begin
               decision.status = rrwl_pkg::ST_OVERFLOW;
            end else begin
               decision.wr_inc = 1'b1;
            end
         end
         rrwl_pkg::OP_WRITE_RELEASE: begin
            if (!wr_flags.busy) begin
               decision.status = rrwl_pkg::ST_NOT_HELD;
            end else begin
               decision.wr_dec = 1'b1;
            end
         end
         default: begin
            decision.status = rrwl_pkg::ST_GRANTED;
         end
      endcase
   end

endmodule

### rtl/core/recursive_reader_writer_lock.sv
// ----------------------------------------------------------------------------
// Recursive reader-writer lock
// Lock unit for a reentrant reader-writer lock: read and write acquire and
// release per thread, with reader slots, recursion and read-to-write upgrade.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Beat
//   req_      in         req_valid / req_stall  req_beat_type (op, thread)
//   rsp_      out        rsp_valid / rsp_stall  rsp_beat_type (status, snapshot)
//
// Every request beat is answered by exactly one response beat, in order.
// A request is held in the input register; the slot match, the decision and
// the state update all happen as it moves into the response register, so one
// beat per cycle is sustained while the response is not stalled.
// Reset empties the reader table and clears the writer depth at once.
// A stalled response holds the input register, and req_stall then rises.
//
module recursive_reader_writer_lock #(
   parameter int READER_SLOTS   = 8,
   parameter int THREAD_ID_BITS = 8,
   parameter int COUNT_BITS     = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rrwl_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rrwl_pkg::rsp_beat_type rsp_data
);

   localparam int RW = $clog2(READER_SLOTS + 1);

   // Input register.
   logic                   req_valid_ff, req_valid_in;
   rrwl_pkg::req_beat_type req_data_ff;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   rrwl_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;

   // Writer state. The owner is only looked at while the depth is nonzero.
   logic [COUNT_BITS-1:0]     writer_depth_ff, writer_depth_in;
   logic [THREAD_ID_BITS-1:0] writer_owner_ff;

   logic                       advance;
   logic [THREAD_ID_BITS-1:0]  tid;
   rrwl_pkg::slot_flags_type   slot_flags;
   rrwl_pkg::writer_flags_type wr_flags;
   rrwl_pkg::decision_type     decision;
   logic [COUNT_BITS-1:0]      own_count, own_after, write_after;
   logic [RW-1:0]              readers, readers_after;
   logic [31:0]                readers_ext, own_ext, write_ext;

   // The held request moves on whenever the response register is empty or is
   // being emptied in this cycle, so the input side only stalls behind a
   // stalled response.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && rsp_valid_ff && rsp_stall;

   assign req_valid_in = req_stall ? req_valid_ff : req_valid;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign tid = THREAD_ID_BITS'(req_data_ff.thread_id);

   assign wr_flags.busy        = (writer_depth_ff != '0);
   assign wr_flags.owner_match = (writer_owner_ff == tid);
   assign wr_flags.depth_max   = &writer_depth_ff;

   rrwl_slot_table #(
      .SLOTS    (READER_SLOTS),
      .TID_BITS (THREAD_ID_BITS),
      .CNT_BITS (COUNT_BITS)
   ) u_slot_table (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .cmd       (decision.slot_cmd),
      .tid       (tid),
      .flags     (slot_flags),
      .own_count (own_count),
      .readers   (readers)
   );

   rrwl_decide u_decide (
      .op         (req_data_ff.req_type),
      .slot_flags (slot_flags),
      .wr_flags   (wr_flags),
      .decision   (decision)
   );

   // Snapshot of the lock as it will stand after this request.
   always_comb begin
      write_after = writer_depth_ff;
      if (decision.wr_inc) begin
         write_after = writer_depth_ff + COUNT_BITS'(1);
      end else if (decision.wr_dec) begin
         write_after = writer_depth_ff - COUNT_BITS'(1);
      end

      readers_after = readers;
      if (decision.slot_cmd.alloc) begin
         readers_after = readers + RW'(1);
      end else if (decision.slot_cmd.dec && slot_flags.count_one) begin
         readers_after = readers - RW'(1);
      end

      // A release that reaches zero leaves the count at zero, which is also
      // what a thread without a slot reports.
      if (slot_flags.hit) begin
         if (decision.slot_cmd.inc) begin
            own_after = own_count + COUNT_BITS'(1);
         end else if (decision.slot_cmd.dec) begin
            own_after = own_count - COUNT_BITS'(1);
         end else begin
            own_after = own_count;
         end
      end else if (decision.slot_cmd.alloc) begin
         own_after = COUNT_BITS'(1);
      end else begin
         own_after = '0;
      end
   end

   assign writer_depth_in = advance ? write_after : writer_depth_ff;

   // The snapshot fields are narrower than the largest configurations allow,
   // so each one saturates at its field's maximum.
   assign readers_ext = 32'(readers_after);
   assign own_ext     = 32'(own_after);
   assign write_ext   = 32'(write_after);

   always_comb begin
      rsp_data_in.status         = decision.status;
      rsp_data_in.reader_threads = (readers_ext > 32'd15)  ? 4'hF  : readers_ext[3:0];
      rsp_data_in.own_read_depth = (own_ext > 32'd255)     ? 8'hFF : own_ext[7:0];
      rsp_data_in.write_nesting  = (write_ext > 32'd255)   ? 8'hFF : write_ext[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         writer_depth_ff <= '0;
      end else begin
         req_valid_ff    <= req_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         writer_depth_ff <= writer_depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (advance && decision.wr_inc) begin
         writer_owner_ff <= tid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A refused request must leave the writer depth alone.
   a_refused_keeps_writer : assert property (@(posedge clock) disable iff (reset)
      advance && (decision.status != rrwl_pkg::ST_GRANTED) |=> $stable(writer_depth_ff))
      else $error("writer depth changed on a refused request");

   // A granted write acquire deepens the writer nesting by exactly one.
   a_write_acquire_step : assert property (@(posedge clock) disable iff (reset)
      advance && decision.wr_inc |=> writer_depth_ff == $past(writer_depth_ff) + COUNT_BITS'(1))
      else $error("write acquire did not raise the depth by one");

   // A held request that cannot move on is not dropped from the input register.
   a_held_request_kept : assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff)
      else $error("held request lost");

   // Every request that moves on produces a response beat.
   a_advance_loads_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response not loaded");

   // A granted write acquire never coexists with another thread's read.
   a_write_excludes_readers : assert property (@(posedge clock) disable iff (reset)
      advance && decision.wr_inc |-> !slot_flags.other_reader)
      else $error("write granted while another thread reads");
`endif

endmodule
